// ----- design/frenet_to_cartesian_defines.svh -----
`ifndef FRENET_TO_CARTESIAN_DEFINES_SVH
`define FRENET_TO_CARTESIAN_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define F2C_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and disabled during rst.
`define F2C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/f2c_pkg.sv -----
`timescale 1ns / 1ps
package f2c_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // 1/K of the CORDIC gain in Q30.
  localparam logic [29:0] KINV = 30'd652032874;
  localparam int MUL_SHIFT    = 14;
  localparam int GUARD_BITS   = 16;
  localparam int CORDIC_STEPS = 32;
  localparam int STEP_W       = 5;

  localparam int A_W   = 36;  // segment vector during vectoring
  localparam int G_W   = 52;  // offset vector with guard bits
  localparam int U_W   = 33;  // seg_s and -d
  localparam int P_W   = 64;  // multiplier product
  localparam int SUM_W = 38;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH_P,
    ST_FETCH_N,
    ST_FETCH_W,
    ST_MUL_U,
    ST_MUL_V,
    ST_PREP,
    ST_ROTATE,
    ST_FINISH
  } state_t;

endpackage

// ----- design/f2c_ram.sv -----
`timescale 1ns / 1ps
module f2c_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/frenet_to_cartesian.sv -----
// A load transaction produces no result. Queries do not overlap.
// A query runs from acceptance to result through a scan of the waypoints in use at
// one table read per cycle, the fetch states FETCH_P, FETCH_N and FETCH_W, the multiply
// states MUL_U and MUL_V, the setup state PREP, 32 CORDIC steps (skipped for a
// zero-length segment) and the finish state, which waits on out_ready while a result is held.
// rst clears control state and sets waypoint_count to 2; tables hold garbage.
`timescale 1ns / 1ps
`include "frenet_to_cartesian_defines.svh"
module frenet_to_cartesian
  import f2c_pkg::*;
#(
  parameter int MAP_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [7:0]         entry_index,
  input  logic signed [31:0] entry_x,
  input  logic signed [31:0] entry_y,
  input  logic [30:0]        entry_s,
  input  logic [30:0]        query_s,
  input  logic signed [31:0] query_d,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y
);

  localparam int AW = $clog2(MAP_DEPTH);
  localparam int CW = $clog2(MAP_DEPTH + 1);

  state_t state, state_next;

  logic [8:0]     waypoint_count;
  logic [CW-1:0]  count_eff;
  logic [31:0]    count_tmp;

  logic [CW-1:0]  idx;
  logic [CW-1:0]  passed;
  logic           cmp_valid;
  logic           scan_stop;
  logic [AW-1:0]  prev;
  logic [AW-1:0]  next;
  logic [AW-1:0]  prev_calc;
  logic [CW-1:0]  prev_inc;

  logic [30:0]        qs;
  logic signed [31:0] qd;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic signed [31:0] x_rdata;
  logic signed [31:0] y_rdata;
  logic [30:0]        s_rdata;

  logic signed [31:0]    x0;
  logic signed [31:0]    y0;
  logic signed [A_W-1:0] a;
  logic signed [A_W-1:0] b;
  logic signed [U_W-1:0] u;
  logic signed [U_W-1:0] v;
  logic signed [G_W-1:0] gu;
  logic signed [G_W-1:0] gv;
  logic signed [P_W-1:0] prod;
  logic                  zero_seg;
  logic [STEP_W-1:0]     step;

  logic signed [U_W-1:0] mul_op;
  logic signed [G_W-1:0] gv_calc;
  logic signed [A_W-1:0] ta;
  logic signed [A_W-1:0] tb;
  logic signed [G_W-1:0] tu;
  logic signed [G_W-1:0] tv;
  logic signed [G_W-1:0] gu_rnd;
  logic signed [G_W-1:0] gv_rnd;
  logic signed [SUM_W-1:0] offx;
  logic signed [SUM_W-1:0] offy;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic                    out_load;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] val);
    logic signed [31:0] res;
    if (val > SUM_W'(signed'(32'sh7fffffff))) begin
      res = 32'sh7fffffff;
    end else if (val < SUM_W'(signed'(-32'sh80000000))) begin
      res = -32'sh80000000;
    end else begin
      res = val[31:0];
    end
    return res;
  endfunction

  always_comb begin
    count_tmp = 32'(waypoint_count);
    if (count_tmp < 32'd2) begin
      count_tmp = 32'd2;
    end else if (count_tmp > 32'(MAP_DEPTH)) begin
      count_tmp = 32'(MAP_DEPTH);
    end
    count_eff = CW'(count_tmp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waypoint_count <= 9'd2;
    end else if (cfg_write) begin
      waypoint_count <= cfg_data;
    end
  end

  // Tables.
  f2c_ram #(.WIDTH(32), .DEPTH(MAP_DEPTH)) u_x_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(entry_x),
    .raddr(ram_raddr), .rdata(x_rdata)
  );
  f2c_ram #(.WIDTH(32), .DEPTH(MAP_DEPTH)) u_y_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(entry_y),
    .raddr(ram_raddr), .rdata(y_rdata)
  );
  f2c_ram #(.WIDTH(31), .DEPTH(MAP_DEPTH)) u_s_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(entry_s),
    .raddr(ram_raddr), .rdata(s_rdata)
  );

  // The scan stops at the first waypoint whose s is not below the query, or after the last one in use.
  assign scan_stop = cmp_valid ? !(qs > s_rdata) : (idx >= count_eff);
  assign prev_calc = (passed == '0) ? '0 : AW'(passed - CW'(1));
  assign prev_inc  = CW'(prev_calc) + CW'(1);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && operation == OP_QUERY) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_stop) begin
          state_next = ST_FETCH_P;
        end
      end
      ST_FETCH_P: state_next = ST_FETCH_N;
      ST_FETCH_N: state_next = ST_FETCH_W;
      ST_FETCH_W: state_next = ST_MUL_U;
      ST_MUL_U:   state_next = ST_MUL_V;
      ST_MUL_V:   state_next = ST_PREP;
      ST_PREP:    state_next = zero_seg ? ST_FINISH : ST_ROTATE;
      ST_ROTATE: begin
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(entry_index);
    ram_raddr = next;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_we   = in_valid && operation == OP_LOAD && 32'(entry_index) < MAP_DEPTH;
      end
      ST_SCAN:    ram_raddr = idx[AW-1:0];
      ST_FETCH_P: ram_raddr = prev;
      ST_FINISH:  out_load = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      passed    <= '0;
      cmp_valid <= 1'b0;
      prev      <= '0;
      next      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          idx       <= '0;
          passed    <= '0;
          cmp_valid <= 1'b0;
        end
        ST_SCAN: begin
          if (idx < count_eff) begin
            idx <= idx + CW'(1);
          end
          cmp_valid <= idx < count_eff;
          if (cmp_valid && qs > s_rdata) begin
            passed <= passed + CW'(1);
          end
          if (scan_stop) begin
            prev <= prev_calc;
            next <= (prev_inc >= count_eff) ? '0 : prev_inc[AW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Shared datapath: one multiplier and one CORDIC rotator.
  assign mul_op  = (state == ST_MUL_U) ? u : v;
  assign gv_calc = G_W'(prod >>> MUL_SHIFT);
  assign ta = a >>> step;
  assign tb = b >>> step;
  assign tu = gu >>> step;
  assign tv = gv >>> step;

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      qs <= query_s;
      qd <= query_d;
    end
    unique case (state)
      ST_FETCH_N: begin
        x0 <= x_rdata;
        y0 <= y_rdata;
        u  <= signed'({2'b00, qs}) - signed'({2'b00, s_rdata});
        v  <= -U_W'(qd);
      end
      ST_FETCH_W: begin
        a <= A_W'(x_rdata) - A_W'(x0);
        b <= A_W'(y_rdata) - A_W'(y0);
      end
      ST_MUL_U: begin
        prod     <= P_W'(mul_op) * signed'({34'd0, KINV});
        zero_seg <= (a == '0) && (b == '0);
      end
      ST_MUL_V: begin
        gu   <= gv_calc;
        prod <= P_W'(mul_op) * signed'({34'd0, KINV});
      end
      ST_PREP: begin
        step <= '0;
        // Turn the segment into the right half plane first.
        if (a[A_W-1]) begin
          a  <= -a;
          b  <= -b;
          gu <= -gu;
          gv <= -gv_calc;
        end else begin
          gv <= gv_calc;
        end
      end
      ST_ROTATE: begin
        step <= step + STEP_W'(1);
        if (!b[A_W-1]) begin
          a  <= a + tb;
          b  <= b - ta;
          gu <= gu - tv;
          gv <= gv + tu;
        end else begin
          a  <= a - tb;
          b  <= b + ta;
          gu <= gu + tv;
          gv <= gv - tu;
        end
      end
      default: begin
      end
    endcase
  end

  assign gu_rnd = (gu + G_W'(1 << (GUARD_BITS - 1))) >>> GUARD_BITS;
  assign gv_rnd = (gv + G_W'(1 << (GUARD_BITS - 1))) >>> GUARD_BITS;
  assign offx   = zero_seg ? SUM_W'(u) : SUM_W'(gu_rnd);
  assign offy   = zero_seg ? SUM_W'(v) : SUM_W'(gv_rnd);
  assign sum_x  = SUM_W'(x0) + offx;
  assign sum_y  = SUM_W'(y0) + offy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x <= sat32(sum_x);
      out_y <= sat32(sum_y);
    end
  end

  `F2C_ASSERT_NEXT(a_query_busy, in_valid && in_ready && operation == OP_QUERY, !in_ready, "query accepted but block still ready")
  `F2C_ASSERT_NOW(a_scan_bound, state == ST_SCAN, passed <= count_eff, "scan passed more waypoints than in use")
  `F2C_ASSERT_NOW(a_out_source, $rose(out_valid), $past(state == ST_FINISH), "result appeared outside finish")

endmodule
